// ----- hdl/psi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the polygon crossing tester.
// Used by psi_core and polygon_segment_intersect; depends on nothing.
package psi_pkg;

  localparam int COORD_W = 32;
  localparam int TOL_W   = 16;

  // Item kinds
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SEG = 2'd1;
  localparam logic [1:0] OP_PNT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // One input item
  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
  } item_t;

  // One result item
  typedef struct packed {
    logic                      hit;
    logic [1:0]                status;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } res_t;

endpackage

// ----- hdl/psi_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psi_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/psi_core.sv -----
`timescale 1ns / 1ps
// Sequencer and datapath of the polygon tester: vertex store, normal, plane
// test and even-odd crossing walk. Depends on psi_pkg and psi_ram.
module psi_core
  import psi_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  item_t            item,
  output logic             idle,
  input  logic [TOL_W-1:0] tol,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_NRD0, S_NRD1, S_NEDGE, S_NCROSS, S_NMAG, S_NNORM, S_NSQ,
    S_NSQRT, S_NDSET, S_NDIV, S_QRD0, S_QRD1, S_QDOT, S_QCHK, S_QDIV, S_QPT,
    S_ERD, S_ELD, S_ECCW, S_EEND, S_DONE
  } state_t;

  typedef logic signed [32:0] pt_t;
  typedef logic signed [33:0] diff_t;

  typedef struct packed {
    logic signed [32:0] f;
    logic signed [32:0] g;
  } pair_t;

  function automatic diff_t sub34(input pt_t x, input pt_t y);
    return 34'(x) - 34'(y);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Pick the projection plane from the normal
  function automatic pair_t proj(input logic nxz, input logic nyz,
                                 input pt_t x, input pt_t y, input pt_t z);
    pair_t p;
    p.f = nxz ? x : y;
    p.g = nxz ? (nyz ? y : z) : z;
    return p;
  endfunction

  state_t state_r;
  logic [CNT_W-1:0] cnt_r, k_r, k_inc;
  logic [1:0] op_r;
  logic signed [31:0] a_r [3];
  logic signed [31:0] b_r [3];
  logic signed [31:0] bmin_r [3];
  logic signed [31:0] bmax_r [3];
  logic signed [31:0] n_r [3];
  pt_t v0_r [3];
  pt_t d_r [3];
  pt_t w_r [3];
  pt_t pt_r [3];
  logic signed [30:0] e_r [6];
  logic signed [61:0] c_r [3];
  logic [61:0] cm_r [3];
  logic [2:0] cneg_r;
  logic [2:0] step_r;
  logic [1:0] i_r;
  logic signed [67:0] p0_r, p1_r;
  logic [63:0] acc_r;
  logic signed [63:0] den_r, num_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [31:0] len_r;
  logic [63:0] dv_rem_r, dv_den_r;
  logic [30:0] dv_feed_r, dv_q_r, t_r;
  logic [4:0] dv_cnt_r;
  pair_t pa_r, pb_r;
  logic [3:0] cc_r;
  logic inside_r, hit_r;
  logic [1:0] status_r;

  // Vertex store
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [95:0] ram_rdata;
  pt_t rd_v [3];

  psi_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES), .AW(ADDR_W)) u_vstore (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({a_r[2], a_r[1], a_r[0]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == S_DISP) && (op_r == OP_ADD) &&
                     (cnt_r != CNT_W'(MAX_VERTICES));
  assign ram_waddr = cnt_r[ADDR_W-1:0];
  assign k_inc     = k_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_v[i] = 33'($signed(ram_rdata[32*i +: 32]));
    end
  end

  // Read address per step
  always_comb begin
    case (state_r)
      S_NRD1:  ram_raddr = ADDR_W'(1);
      S_ERD:   ram_raddr = (k_inc == cnt_r) ? '0 : k_inc[ADDR_W-1:0];
      default: ram_raddr = '0;
    endcase
  end

  // Edge vectors of the first triangle, scaled below 2^30
  logic signed [32:0] ev [6];
  logic [32:0] em [6];
  logic [32:0] eor;
  logic [1:0] esh;
  logic [32:0] esm [6];
  logic signed [30:0] es [6];

  always_comb begin
    eor = '0;
    for (int i = 0; i < 3; i++) begin
      ev[i]     = v0_r[i] - rd_v[i];
      ev[3 + i] = 33'(a_r[i]) - rd_v[i];
    end
    for (int i = 0; i < 6; i++) begin
      em[i] = ev[i][32] ? 33'(-ev[i]) : 33'(ev[i]);
      eor   = eor | em[i];
    end
    if (eor[32]) esh = 2'd3;
    else if (eor[31]) esh = 2'd2;
    else if (eor[30]) esh = 2'd1;
    else esh = 2'd0;
    for (int i = 0; i < 6; i++) begin
      esm[i] = em[i] >> esh;
      es[i]  = ev[i][32] ? -$signed({1'b0, esm[i][29:0]}) : $signed({1'b0, esm[i][29:0]});
    end
  end

  // Magnitudes of the cross product and normalization tests
  logic [61:0] cmag [3];
  logic c_zero, cm_hi, cm_lo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][61] ? 62'(-c_r[i]) : 62'(c_r[i]);
    end
    c_zero = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    cm_hi  = |(cm_r[0][61:31] | cm_r[1][61:31] | cm_r[2][61:31]);
    cm_lo  = !(|(cm_r[0][61:30] | cm_r[1][61:30] | cm_r[2][61:30]));
  end

  // Projected outside point and query point
  logic nxz, nyz;
  pair_t po, pp, cs, ce, cq;
  pt_t ov [3];

  always_comb begin
    nxz = (n_r[0] == '0);
    nyz = (n_r[1] == '0);
    for (int i = 0; i < 3; i++) begin
      ov[i] = 33'(bmin_r[i]) - 33'sd65536;
    end
    po = proj(nxz, nyz, ov[0], ov[1], ov[2]);
    pp = proj(nxz, nyz, pt_r[0], pt_r[1], pt_r[2]);
  end

  // Orientation operands: (O,P,A) (O,P,B) (A,B,O) (A,B,P)
  always_comb begin
    cs = po;
    ce = pp;
    cq = pa_r;
    case (step_r)
      3'd1: cq = pb_r;
      3'd2: begin
        cs = pa_r;
        ce = pb_r;
        cq = po;
      end
      3'd3: begin
        cs = pa_r;
        ce = pb_r;
        cq = pp;
      end
      default: ;
    endcase
  end

  // Shared multipliers
  logic [1:0] sel, pidx;
  logic [32:0] dmag [3];
  diff_t ma0, mb0, ma1, mb1;
  logic signed [67:0] prod0, prod1;

  always_comb begin
    sel  = (step_r < 3'd3) ? step_r[1:0] : 2'd0;
    pidx = 2'(step_r - 3'd1);
    for (int i = 0; i < 3; i++) begin
      dmag[i] = d_r[i][32] ? 33'(-d_r[i]) : 33'(d_r[i]);
    end
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    case (state_r)
      S_NCROSS: begin
        case (step_r)
          3'd0: begin
            ma0 = 34'(e_r[1]); mb0 = 34'(e_r[5]);
            ma1 = 34'(e_r[2]); mb1 = 34'(e_r[4]);
          end
          3'd1: begin
            ma0 = 34'(e_r[2]); mb0 = 34'(e_r[3]);
            ma1 = 34'(e_r[0]); mb1 = 34'(e_r[5]);
          end
          3'd2: begin
            ma0 = 34'(e_r[0]); mb0 = 34'(e_r[4]);
            ma1 = 34'(e_r[1]); mb1 = 34'(e_r[3]);
          end
          default: ;
        endcase
      end
      S_NSQ: begin
        case (step_r)
          3'd0: begin
            ma0 = {3'b0, cm_r[0][30:0]}; mb0 = {3'b0, cm_r[0][30:0]};
            ma1 = {3'b0, cm_r[1][30:0]}; mb1 = {3'b0, cm_r[1][30:0]};
          end
          3'd1: begin
            ma0 = {3'b0, cm_r[2][30:0]}; mb0 = {3'b0, cm_r[2][30:0]};
          end
          default: ;
        endcase
      end
      S_QDOT: begin
        ma0 = 34'(d_r[sel]);
        mb0 = 34'(n_r[sel]);
        ma1 = 34'(w_r[sel]);
        mb1 = 34'(n_r[sel]);
      end
      S_QPT: begin
        ma0 = {1'b0, dmag[sel]};
        mb0 = {3'b0, t_r};
      end
      S_ECCW: begin
        ma0 = sub34(cs.g, ce.g);
        mb0 = sub34(cq.f, ce.f);
        ma1 = sub34(ce.g, cq.g);
        mb1 = sub34(ce.f, cs.f);
      end
      default: ;
    endcase
  end

  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;

  // Square root step
  logic [63:0] sq_sum, sq_v_nxt, sq_res_nxt;

  always_comb begin
    sq_sum = sq_res_r + sq_bit_r;
    if (sq_v_r >= sq_sum) begin
      sq_v_nxt   = sq_v_r - sq_sum;
      sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
    end else begin
      sq_v_nxt   = sq_v_r;
      sq_res_nxt = sq_res_r >> 1;
    end
  end

  // Restoring divider step
  logic [64:0] dv_trial;
  logic dv_ge;
  logic [63:0] dv_rem_nxt;
  logic [30:0] dv_q_nxt;

  always_comb begin
    dv_trial   = {dv_rem_r, dv_feed_r[30]};
    dv_ge      = dv_trial >= {1'b0, dv_den_r};
    dv_rem_nxt = dv_ge ? 64'(dv_trial - {1'b0, dv_den_r}) : dv_trial[63:0];
    dv_q_nxt   = {dv_q_r[29:0], dv_ge};
  end

  // Plane checks and per-step arithmetic
  logic [63:0] an, ad, thr;
  logic [61:0] ndiv;
  logic [63:0] pt_add;
  logic signed [34:0] pt_m, pt_sum;
  logic tog;

  always_comb begin
    an     = mag64(num_r);
    ad     = mag64(den_r);
    thr    = {18'b0, tol, 30'b0};
    ndiv   = {1'b0, cm_r[i_r][30:0], 30'b0} + {31'b0, len_r[31:1]};
    pt_add = p0_r[63:0] + 64'h2000_0000;
    pt_m   = $signed({1'b0, pt_add[63:30]});
    pt_sum = 35'(a_r[pidx]) + (d_r[pidx][32] ? -pt_m : pt_m);
    tog    = (cc_r[0] ^ cc_r[1]) & (cc_r[2] ^ cc_r[3]);
  end

  always_ff @(posedge clk) begin
    p0_r <= prod0;
    p1_r <= prod1;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        n_r[i]    <= '0;
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= item.op;
            a_r[0]  <= item.a_x;
            a_r[1]  <= item.a_y;
            a_r[2]  <= item.a_z;
            b_r[0]  <= item.b_x;
            b_r[1]  <= item.b_y;
            b_r[2]  <= item.b_z;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          hit_r    <= 1'b0;
          status_r <= ST_OK;
          case (op_r)
            OP_ADD: begin
              if (cnt_r == CNT_W'(MAX_VERTICES)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                // Widen the box and append the vertex
                for (int i = 0; i < 3; i++) begin
                  if (a_r[i] < bmin_r[i]) bmin_r[i] <= a_r[i];
                  if (a_r[i] > bmax_r[i]) bmax_r[i] <= a_r[i];
                end
                cnt_r   <= cnt_r + CNT_W'(1);
                state_r <= (cnt_r == CNT_W'(2)) ? S_NRD0 : S_DONE;
              end
            end
            OP_SEG, OP_PNT: begin
              if (cnt_r < CNT_W'(3)) begin
                status_r <= ST_FEW;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_QRD0;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        // Normal from the first three vertices
        S_NRD0: state_r <= S_NRD1;
        S_NRD1: begin
          for (int i = 0; i < 3; i++) v0_r[i] <= rd_v[i];
          state_r <= S_NEDGE;
        end
        S_NEDGE: begin
          for (int i = 0; i < 6; i++) e_r[i] <= es[i];
          step_r  <= '0;
          state_r <= S_NCROSS;
        end
        S_NCROSS: begin
          if (step_r != 3'd0) c_r[pidx] <= 62'(p0_r - p1_r);
          step_r <= step_r + 3'd1;
          if (step_r == 3'd3) state_r <= S_NMAG;
        end
        S_NMAG: begin
          for (int i = 0; i < 3; i++) begin
            cm_r[i]   <= cmag[i];
            cneg_r[i] <= c_r[i][61];
          end
          if (c_zero) begin
            for (int i = 0; i < 3; i++) n_r[i] <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_NNORM;
          end
        end
        S_NNORM: begin
          // Shift one bit at a time until the largest lies in [2^30, 2^31)
          if (cm_hi) begin
            for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] >> 1;
          end else if (cm_lo) begin
            for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] << 1;
          end else begin
            step_r  <= '0;
            state_r <= S_NSQ;
          end
        end
        S_NSQ: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd1) acc_r <= p0_r[63:0] + p1_r[63:0];
          if (step_r == 3'd2) begin
            sq_v_r   <= acc_r + p0_r[63:0];
            sq_res_r <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            state_r  <= S_NSQRT;
          end
        end
        S_NSQRT: begin
          sq_v_r   <= sq_v_nxt;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            len_r   <= sq_res_nxt[31:0];
            i_r     <= '0;
            state_r <= S_NDSET;
          end
        end
        S_NDSET: begin
          dv_rem_r  <= {33'b0, ndiv[61:31]};
          dv_feed_r <= ndiv[30:0];
          dv_den_r  <= {32'b0, len_r};
          dv_q_r    <= '0;
          dv_cnt_r  <= 5'd31;
          state_r   <= S_NDIV;
        end
        S_NDIV: begin
          dv_rem_r  <= dv_rem_nxt;
          dv_q_r    <= dv_q_nxt;
          dv_feed_r <= dv_feed_r << 1;
          dv_cnt_r  <= dv_cnt_r - 5'd1;
          if (dv_cnt_r == 5'd1) begin
            n_r[i_r] <= cneg_r[i_r] ? -$signed({1'b0, dv_q_nxt}) : $signed({1'b0, dv_q_nxt});
            if (i_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + 2'd1;
              state_r <= S_NDSET;
            end
          end
        end
        // Plane distances of the query
        S_QRD0: state_r <= S_QRD1;
        S_QRD1: begin
          for (int i = 0; i < 3; i++) begin
            v0_r[i] <= rd_v[i];
            d_r[i]  <= 33'(b_r[i]) - 33'(a_r[i]);
            w_r[i]  <= (op_r == OP_SEG) ? rd_v[i] - 33'(a_r[i]) : 33'(a_r[i]) - rd_v[i];
          end
          den_r   <= '0;
          num_r   <= '0;
          step_r  <= '0;
          state_r <= S_QDOT;
        end
        S_QDOT: begin
          if (step_r != 3'd0) begin
            den_r <= den_r + p0_r[63:0];
            num_r <= num_r + p1_r[63:0];
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd3) state_r <= S_QCHK;
        end
        S_QCHK: begin
          if (op_r == OP_SEG) begin
            if (ad == '0 || ad < thr || (num_r != '0 && num_r[63] != den_r[63]) || an > ad) begin
              state_r <= S_DONE;
            end else if (an == ad) begin
              t_r     <= 31'h4000_0000;
              step_r  <= '0;
              state_r <= S_QPT;
            end else begin
              dv_rem_r  <= an;
              dv_den_r  <= ad;
              dv_feed_r <= '0;
              dv_q_r    <= '0;
              dv_cnt_r  <= 5'd30;
              state_r   <= S_QDIV;
            end
          end else if (an > thr) begin
            state_r <= S_DONE;
          end else begin
            for (int i = 0; i < 3; i++) pt_r[i] <= 33'(a_r[i]);
            k_r      <= '0;
            pa_r     <= proj(nxz, nyz, v0_r[0], v0_r[1], v0_r[2]);
            inside_r <= 1'b0;
            state_r  <= S_ERD;
          end
        end
        S_QDIV: begin
          dv_rem_r  <= dv_rem_nxt;
          dv_q_r    <= dv_q_nxt;
          dv_feed_r <= dv_feed_r << 1;
          dv_cnt_r  <= dv_cnt_r - 5'd1;
          if (dv_cnt_r == 5'd1) begin
            t_r     <= dv_q_nxt;
            step_r  <= '0;
            state_r <= S_QPT;
          end
        end
        S_QPT: begin
          if (step_r != 3'd0) pt_r[pidx] <= 33'(pt_sum);
          step_r <= step_r + 3'd1;
          if (step_r == 3'd3) begin
            k_r      <= '0;
            pa_r     <= proj(nxz, nyz, v0_r[0], v0_r[1], v0_r[2]);
            inside_r <= 1'b0;
            state_r  <= S_ERD;
          end
        end
        // Edge walk: one stored vertex fetched per edge
        S_ERD: state_r <= S_ELD;
        S_ELD: begin
          pb_r    <= proj(nxz, nyz, rd_v[0], rd_v[1], rd_v[2]);
          step_r  <= '0;
          state_r <= S_ECCW;
        end
        S_ECCW: begin
          if (step_r != 3'd0) cc_r[pidx] <= p0_r > p1_r;
          step_r <= step_r + 3'd1;
          if (step_r == 3'd4) state_r <= S_EEND;
        end
        S_EEND: begin
          inside_r <= inside_r ^ tog;
          pa_r     <= pb_r;
          k_r      <= k_inc;
          if (k_inc == cnt_r) begin
            hit_r   <= inside_r ^ tog;
            state_r <= S_DONE;
          end else begin
            state_r <= S_ERD;
          end
        end
        S_DONE: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle          = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.hit       = hit_r;
  assign res.status    = status_r;
  assign res.box_min_x = bmin_r[0];
  assign res.box_min_y = bmin_r[1];
  assign res.box_min_z = bmin_r[2];
  assign res.box_max_x = bmax_r[0];
  assign res.box_max_y = bmax_r[1];
  assign res.box_max_z = bmax_r[2];

endmodule

// ----- hdl/polygon_segment_intersect.sv -----
`timescale 1ns / 1ps
// Top level of the planar polygon tester: config register, input and
// output stream channels. Depends on psi_pkg and psi_core.
//
// Usage: the in_ channel carries one item per transfer: the kind in
// in_tuser (add vertex, segment query, point query) and the coordinates in
// in_tdata. Every accepted item gives exactly one transfer on the out_
// channel with hit, status and the current bounding box.
// cfg_we writes plane_tolerance; write it only while no item is in flight.
// Operation: items are handled one at a time by a sequencer around a vertex
// RAM with one write and one read port. The third add also computes the
// normal: a shift loop, a 32-step square root and three 31-step divisions.
// A query walks the N stored vertices as edges: each edge costs one RAM read
// and four orientation tests on two shared multipliers; a segment query may
// first run the 30-step division for the crossing point.
// Reset clears the vertex count, box, normal and sets the tolerance to 1;
// no clearing pass is needed. A stalled receiver holds the result in the
// output register; the next item is still accepted and finishes into the
// sequencer, which then waits until the output register frees.
module polygon_segment_intersect
  import psi_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,   // plane_tolerance
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,    // a_x, a_y, a_z, b_x, b_y, b_z
  input  logic [1:0]   in_tuser,    // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata    // hit, status, box_min_x/y/z, box_max_x/y/z, pad
);

  logic [TOL_W-1:0] tol_r;
  item_t item;
  logic core_idle, res_valid, res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign item.op  = in_tuser;
  assign item.a_x = in_tdata[31:0];
  assign item.a_y = in_tdata[63:32];
  assign item.a_z = in_tdata[95:64];
  assign item.b_x = in_tdata[127:96];
  assign item.b_y = in_tdata[159:128];
  assign item.b_z = in_tdata[191:160];

  psi_core #(.MAX_VERTICES(MAX_VERTICES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid & core_idle),
    .item      (item),
    .idle      (core_idle),
    .tol       (tol_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  // Output register: load a finished result, drop it after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.box_max_z, out_r.box_max_y, out_r.box_max_x,
                       out_r.box_min_z, out_r.box_min_y, out_r.box_min_x,
                       out_r.status, out_r.hit};

endmodule
